>>> design/ip_port_allow_block_filter_assert.svh
// Assertion macros shared by the packet filter RTL.
// Users must provide clk_i and rst_ni in the including scope.
`ifndef IP_PORT_ALLOW_BLOCK_FILTER_ASSERT_SVH
`define IP_PORT_ALLOW_BLOCK_FILTER_ASSERT_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define IPF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipf assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define IPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipf assertion failed");

`endif

>>> design/ipf_pkg.sv
// Shared constants, types and key helper for the IP allow/block filter.
// No dependencies; the design modules refer to it by scoped names and the testbench imports it.
package ipf_pkg;

  localparam int ALLOW_ENTRIES = 64;
  localparam int BLOCK_ENTRIES = 64;
  localparam int SCAN_ENTRIES  = (ALLOW_ENTRIES > BLOCK_ENTRIES) ? ALLOW_ENTRIES
                                                                 : BLOCK_ENTRIES;
  localparam int SCAN_W   = (SCAN_ENTRIES > 1) ? $clog2(SCAN_ENTRIES) : 1;
  localparam int ALLOW_AW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
  localparam int BLOCK_AW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int KEY_W    = 57;
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] MIN_IP_LEN   = 16'd34;
  localparam logic [15:0] MIN_PORT_LEN = 16'd54;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ALLOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_BLOCK = 8'd1;

  typedef enum logic [2:0] {
    MODE_INGRESS   = 3'd0,
    MODE_EGRESS    = 3'd1,
    MODE_INS_ALLOW = 3'd2,
    MODE_INS_BLOCK = 3'd3,
    MODE_DEL_ALLOW = 3'd4,
    MODE_DEL_BLOCK = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    RSN_GLOBAL_ALLOW   = 4'd0,
    RSN_NOT_IPV4       = 4'd1,
    RSN_ALLOW_SRC_PORT = 4'd2,
    RSN_ALLOW_DST_PORT = 4'd3,
    RSN_ALLOW_SRC      = 4'd4,
    RSN_ALLOW_DST      = 4'd5,
    RSN_GLOBAL_BLOCK   = 4'd6,
    RSN_BLOCK_SRC_PORT = 4'd7,
    RSN_BLOCK_DST_PORT = 4'd8,
    RSN_BLOCK_SRC      = 4'd9,
    RSN_BLOCK_DST      = 4'd10,
    RSN_NONE           = 4'd11
  } reason_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [31:0] rule_ip;
    logic [7:0]  rule_proto;
    logic        rule_direction;
    logic [15:0] rule_port;
  } req_t;

  typedef struct packed {
    logic       verdict;
    logic [3:0] match_reason;
    logic [1:0] op_status;
  } rslt_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [KEY_W-1:0] make_key(input logic [31:0] ip,
                                                input logic [7:0]  proto,
                                                input logic        dir,
                                                input logic [15:0] port);
    return {ip, proto, dir, port};
  endfunction

endpackage

>>> design/ipf_if.sv
// Handshake channel interfaces for the IP allow/block filter.
// Header, result and configuration channels; widths follow the field list.
interface ipf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] frame_len;
  logic [15:0] ether_type;
  logic [7:0]  ip_proto;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;
  logic [31:0] rule_ip;
  logic [7:0]  rule_proto;
  logic        rule_direction;
  logic [15:0] rule_port;

  modport source (
    output valid, mode, frame_len, ether_type, ip_proto, src_ip, dst_ip,
           l4_sport, l4_dport, rule_ip, rule_proto, rule_direction, rule_port,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_len, ether_type, ip_proto, src_ip, dst_ip,
           l4_sport, l4_dport, rule_ip, rule_proto, rule_direction, rule_port,
    output ready
  );
endinterface

interface ipf_out_if;
  logic       valid;
  logic       ready;
  logic       verdict;
  logic [3:0] match_reason;
  logic [1:0] op_status;

  modport source (output valid, verdict, match_reason, op_status, input ready);
  modport sink (input valid, verdict, match_reason, op_status, output ready);
endinterface

interface ipf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] idx;
  logic       data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

>>> design/ipf_ctrl.sv
// Sequencer for the IP allow/block filter: accept, table scan, drain, commit.
// Depends on ipf_pkg for the state type and the command and status structs.
module ipf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ipf_pkg::dp_sts_t   sts_i,
  output ipf_pkg::ctrl_cmd_t cmd_o
);

  ipf_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ipf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ipf_pkg::S_SCAN;
        end
      end
      ipf_pkg::S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ipf_pkg::S_DRAIN;
        end
      end
      ipf_pkg::S_DRAIN: begin
        state_d = ipf_pkg::S_COMMIT;
      end
      ipf_pkg::S_COMMIT: begin
        if (sts_i.out_free) begin
          state_d = ipf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ipf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.start  = 1'b0;
    cmd_o.scan   = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ipf_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ipf_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ipf_pkg::S_DRAIN: begin
        cmd_o.scan = 1'b0;
      end
      ipf_pkg::S_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> design/ipf_dp.sv
// Datapath of the IP allow/block filter: rule memories, scan compare, verdict and
// output register. Depends on ipf_pkg; driven by ipf_ctrl commands.
module ipf_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ipf_pkg::ctrl_cmd_t               cmd_i,
  output ipf_pkg::dp_sts_t                 sts_o,
  input  ipf_pkg::req_t                    req_i,
  input  logic                             cfg_we_i,
  input  logic [ipf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic                             cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ipf_pkg::rslt_t                   out_data_o
);

  localparam int HIT_SP = 0;
  localparam int HIT_DP = 1;
  localparam int HIT_S  = 2;
  localparam int HIT_D  = 3;
  localparam logic [ipf_pkg::SCAN_W:0] ALLOW_LIM =
    (ipf_pkg::SCAN_W+1)'(ipf_pkg::ALLOW_ENTRIES);
  localparam logic [ipf_pkg::SCAN_W:0] BLOCK_LIM =
    (ipf_pkg::SCAN_W+1)'(ipf_pkg::BLOCK_ENTRIES);
  localparam logic [ipf_pkg::SCAN_W-1:0] SCAN_LAST =
    ipf_pkg::SCAN_W'(ipf_pkg::SCAN_ENTRIES - 1);

  ipf_pkg::req_t                   req_q;
  logic                            gl_allow_q;
  logic                            gl_block_q;
  logic [ipf_pkg::SCAN_W-1:0]      scan_cnt_q;

  logic [ipf_pkg::KEY_W-1:0]       allow_mem [ipf_pkg::ALLOW_ENTRIES];
  logic [ipf_pkg::KEY_W-1:0]       block_mem [ipf_pkg::BLOCK_ENTRIES];
  logic [ipf_pkg::ALLOW_ENTRIES-1:0] allow_vld_q;
  logic [ipf_pkg::BLOCK_ENTRIES-1:0] block_vld_q;

  logic                            rd_en_q;
  logic [ipf_pkg::SCAN_W-1:0]      rd_idx_q;
  logic [ipf_pkg::KEY_W-1:0]       a_key_q;
  logic [ipf_pkg::KEY_W-1:0]       b_key_q;
  logic                            a_ok_q;
  logic                            b_ok_q;
  logic                            a_in_q;
  logic                            b_in_q;

  logic [3:0]                      a_hit_q;
  logic [3:0]                      b_hit_q;
  logic                            op_found_q;
  logic [ipf_pkg::SCAN_W-1:0]      op_idx_q;
  logic                            free_found_q;
  logic [ipf_pkg::SCAN_W-1:0]      free_idx_q;

  logic                            out_valid_q;
  ipf_pkg::rslt_t                  out_q;

  logic [ipf_pkg::ALLOW_AW-1:0]    a_idx;
  logic [ipf_pkg::BLOCK_AW-1:0]    b_idx;
  logic                            a_in;
  logic                            b_in;
  logic                            ports_on;
  logic [15:0]                     sport_eff;
  logic [15:0]                     dport_eff;
  logic [ipf_pkg::KEY_W-1:0]       k_sp;
  logic [ipf_pkg::KEY_W-1:0]       k_dp;
  logic [ipf_pkg::KEY_W-1:0]       k_s;
  logic [ipf_pkg::KEY_W-1:0]       k_d;
  logic [ipf_pkg::KEY_W-1:0]       k_rule;
  logic                            op_blk;
  logic [ipf_pkg::KEY_W-1:0]       sel_key;
  logic                            sel_ok;
  logic                            sel_in;
  logic [3:0]                      a_hit_now;
  logic [3:0]                      b_hit_now;

  logic                            egress;
  logic                            good;
  logic [3:0]                      reason;
  ipf_pkg::rslt_t                  rslt_d;
  logic                            a_set;
  logic                            a_clr;
  logic                            b_set;
  logic                            b_clr;
  logic [ipf_pkg::ALLOW_AW-1:0]    a_waddr;
  logic [ipf_pkg::BLOCK_AW-1:0]    b_waddr;

  assign a_idx = scan_cnt_q[ipf_pkg::ALLOW_AW-1:0];
  assign b_idx = scan_cnt_q[ipf_pkg::BLOCK_AW-1:0];
  assign a_in  = {1'b0, scan_cnt_q} < ALLOW_LIM;
  assign b_in  = {1'b0, scan_cnt_q} < BLOCK_LIM;

  // Ports join the key only for TCP or UDP with a full transport header.
  assign ports_on  = ((req_q.ip_proto == ipf_pkg::PROTO_TCP) ||
                      (req_q.ip_proto == ipf_pkg::PROTO_UDP)) &&
                     (req_q.frame_len >= ipf_pkg::MIN_PORT_LEN);
  assign sport_eff = ports_on ? req_q.l4_sport : 16'd0;
  assign dport_eff = ports_on ? req_q.l4_dport : 16'd0;

  assign k_sp   = ipf_pkg::make_key(req_q.src_ip, req_q.ip_proto, 1'b0, sport_eff);
  assign k_dp   = ipf_pkg::make_key(req_q.dst_ip, req_q.ip_proto, 1'b1, dport_eff);
  assign k_s    = ipf_pkg::make_key(req_q.src_ip, req_q.ip_proto, 1'b0, 16'd0);
  assign k_d    = ipf_pkg::make_key(req_q.dst_ip, req_q.ip_proto, 1'b1, 16'd0);
  assign k_rule = ipf_pkg::make_key(req_q.rule_ip, req_q.rule_proto,
                                    req_q.rule_direction, req_q.rule_port);

  assign op_blk  = req_q.mode[0];
  assign sel_key = op_blk ? b_key_q : a_key_q;
  assign sel_ok  = op_blk ? b_ok_q : a_ok_q;
  assign sel_in  = op_blk ? b_in_q : a_in_q;

  assign a_hit_now[HIT_SP] = a_ok_q && (a_key_q == k_sp);
  assign a_hit_now[HIT_DP] = a_ok_q && (a_key_q == k_dp);
  assign a_hit_now[HIT_S]  = a_ok_q && (a_key_q == k_s);
  assign a_hit_now[HIT_D]  = a_ok_q && (a_key_q == k_d);
  assign b_hit_now[HIT_SP] = b_ok_q && (b_key_q == k_sp);
  assign b_hit_now[HIT_DP] = b_ok_q && (b_key_q == k_dp);
  assign b_hit_now[HIT_S]  = b_ok_q && (b_key_q == k_s);
  assign b_hit_now[HIT_D]  = b_ok_q && (b_key_q == k_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gl_allow_q <= 1'b0;
      gl_block_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ipf_pkg::CFG_GLOBAL_ALLOW) begin
        gl_allow_q <= cfg_data_i;
      end
      if (cfg_idx_i == ipf_pkg::CFG_GLOBAL_BLOCK) begin
        gl_block_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.start) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan && (scan_cnt_q != SCAN_LAST)) begin
      scan_cnt_q <= scan_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      a_key_q <= allow_mem[a_idx];
    end
    if (a_set) begin
      allow_mem[a_waddr] <= k_rule;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      b_key_q <= block_mem[b_idx];
    end
    if (b_set) begin
      block_mem[b_waddr] <= k_rule;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_idx_q <= scan_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_en_q <= 1'b0;
      a_ok_q  <= 1'b0;
      b_ok_q  <= 1'b0;
      a_in_q  <= 1'b0;
      b_in_q  <= 1'b0;
    end else begin
      rd_en_q <= cmd_i.scan;
      a_ok_q  <= cmd_i.scan && a_in && allow_vld_q[a_idx];
      b_ok_q  <= cmd_i.scan && b_in && block_vld_q[b_idx];
      a_in_q  <= cmd_i.scan && a_in;
      b_in_q  <= cmd_i.scan && b_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hit_q      <= '0;
      b_hit_q      <= '0;
      op_found_q   <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.start) begin
      a_hit_q      <= '0;
      b_hit_q      <= '0;
      op_found_q   <= 1'b0;
      free_found_q <= 1'b0;
    end else if (rd_en_q) begin
      a_hit_q <= a_hit_q | a_hit_now;
      b_hit_q <= b_hit_q | b_hit_now;
      if (sel_ok && (sel_key == k_rule)) begin
        op_found_q <= 1'b1;
      end
      if (sel_in && !sel_ok) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_q && sel_ok && (sel_key == k_rule) && !op_found_q) begin
      op_idx_q <= rd_idx_q;
    end
    if (rd_en_q && sel_in && !sel_ok && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  assign egress = (req_q.mode == ipf_pkg::MODE_EGRESS);
  assign good   = (req_q.frame_len >= ipf_pkg::MIN_IP_LEN) &&
                  (req_q.ether_type == ipf_pkg::ETH_IPV4);

  always_comb begin
    if (egress && gl_allow_q) begin
      reason = ipf_pkg::RSN_GLOBAL_ALLOW;
    end else if (!good) begin
      reason = ipf_pkg::RSN_NOT_IPV4;
    end else if (gl_allow_q) begin
      reason = ipf_pkg::RSN_GLOBAL_ALLOW;
    end else if (!egress && a_hit_q[HIT_SP]) begin
      reason = ipf_pkg::RSN_ALLOW_SRC_PORT;
    end else if (a_hit_q[HIT_DP]) begin
      reason = ipf_pkg::RSN_ALLOW_DST_PORT;
    end else if (!egress && a_hit_q[HIT_S]) begin
      reason = ipf_pkg::RSN_ALLOW_SRC;
    end else if (a_hit_q[HIT_D]) begin
      reason = ipf_pkg::RSN_ALLOW_DST;
    end else if (gl_block_q) begin
      reason = ipf_pkg::RSN_GLOBAL_BLOCK;
    end else if (!egress && b_hit_q[HIT_SP]) begin
      reason = ipf_pkg::RSN_BLOCK_SRC_PORT;
    end else if (b_hit_q[HIT_DP]) begin
      reason = ipf_pkg::RSN_BLOCK_DST_PORT;
    end else if (!egress && b_hit_q[HIT_S]) begin
      reason = ipf_pkg::RSN_BLOCK_SRC;
    end else if (b_hit_q[HIT_D]) begin
      reason = ipf_pkg::RSN_BLOCK_DST;
    end else begin
      reason = ipf_pkg::RSN_NONE;
    end
  end

  always_comb begin
    rslt_d.verdict      = 1'b0;
    rslt_d.match_reason = ipf_pkg::RSN_NONE;
    rslt_d.op_status    = ipf_pkg::STAT_OK;
    a_set = 1'b0;
    a_clr = 1'b0;
    b_set = 1'b0;
    b_clr = 1'b0;
    case (req_q.mode)
      ipf_pkg::MODE_INGRESS, ipf_pkg::MODE_EGRESS: begin
        rslt_d.match_reason = reason;
        rslt_d.verdict      = (reason >= ipf_pkg::RSN_GLOBAL_BLOCK) &&
                              (reason <= ipf_pkg::RSN_BLOCK_DST);
      end
      ipf_pkg::MODE_INS_ALLOW: begin
        if (!op_found_q && !free_found_q) begin
          rslt_d.op_status = ipf_pkg::STAT_FULL;
        end
        a_set = cmd_i.commit && !op_found_q && free_found_q;
      end
      ipf_pkg::MODE_INS_BLOCK: begin
        if (!op_found_q && !free_found_q) begin
          rslt_d.op_status = ipf_pkg::STAT_FULL;
        end
        b_set = cmd_i.commit && !op_found_q && free_found_q;
      end
      ipf_pkg::MODE_DEL_ALLOW: begin
        if (!op_found_q) begin
          rslt_d.op_status = ipf_pkg::STAT_MISSING;
        end
        a_clr = cmd_i.commit && op_found_q;
      end
      ipf_pkg::MODE_DEL_BLOCK: begin
        if (!op_found_q) begin
          rslt_d.op_status = ipf_pkg::STAT_MISSING;
        end
        b_clr = cmd_i.commit && op_found_q;
      end
      default: begin
        rslt_d.op_status = ipf_pkg::STAT_OK;
      end
    endcase
  end

  assign a_waddr = a_set ? free_idx_q[ipf_pkg::ALLOW_AW-1:0]
                         : op_idx_q[ipf_pkg::ALLOW_AW-1:0];
  assign b_waddr = b_set ? free_idx_q[ipf_pkg::BLOCK_AW-1:0]
                         : op_idx_q[ipf_pkg::BLOCK_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_vld_q <= '0;
      block_vld_q <= '0;
    end else begin
      if (a_set || a_clr) begin
        allow_vld_q[a_waddr] <= a_set;
      end
      if (b_set || b_clr) begin
        block_vld_q[b_waddr] <= b_set;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= rslt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.scan_last = (scan_cnt_q == SCAN_LAST);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> design/ip_port_allow_block_filter.sv
// An accepted transaction scans both rule tables, drains, then commits its result; commit
// waits while the previous result is still unaccepted. One transaction is in flight at a time;
// both rule memories are scanned through one read port each, one entry per cycle.
// Reset: rst_ni clears every rule valid bit and both global flags at once; no clearing pass.
// Configuration is taken in any cycle with ready held high.
module ip_port_allow_block_filter (
  input logic       clk_i,
  input logic       rst_ni,
  ipf_in_if.sink    in_i,
  ipf_out_if.source out_o,
  ipf_cfg_if.sink   cfg_i
);

`include "ip_port_allow_block_filter_assert.svh"

  ipf_pkg::req_t      req;
  ipf_pkg::rslt_t     rslt;
  ipf_pkg::ctrl_cmd_t cmd;
  ipf_pkg::dp_sts_t   sts;
  logic               out_valid;
  logic               in_ready;
  logic               op_out;
  logic               op_quiet;

  assign req.mode           = in_i.mode;
  assign req.frame_len      = in_i.frame_len;
  assign req.ether_type     = in_i.ether_type;
  assign req.ip_proto       = in_i.ip_proto;
  assign req.src_ip         = in_i.src_ip;
  assign req.dst_ip         = in_i.dst_ip;
  assign req.l4_sport       = in_i.l4_sport;
  assign req.l4_dport       = in_i.l4_dport;
  assign req.rule_ip        = in_i.rule_ip;
  assign req.rule_proto     = in_i.rule_proto;
  assign req.rule_direction = in_i.rule_direction;
  assign req.rule_port      = in_i.rule_port;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  ipf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.idx),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (rslt)
  );

  assign out_o.valid        = out_valid;
  assign out_o.verdict      = rslt.verdict;
  assign out_o.match_reason = rslt.match_reason;
  assign out_o.op_status    = rslt.op_status;

  assign op_out   = out_valid && (rslt.op_status != ipf_pkg::STAT_OK);
  assign op_quiet = !rslt.verdict && (rslt.match_reason == ipf_pkg::RSN_NONE);

  `IPF_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_ready, !in_ready)
  `IPF_ASSERT_SAME(a_commit_needs_room, cmd.commit, sts.out_free)
  `IPF_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid)
  `IPF_ASSERT_SAME(a_table_op_no_verdict, op_out, op_quiet)

endmodule

>>> tb/tb_ip_port_allow_block_filter.sv
// Self-checking testbench for the IP allow/block packet filter.
// Depends on ipf_pkg, the ipf_*_if channel interfaces and the filter RTL.
// Every result is checked against an in-bench model of the rule tables.
module tb_ip_port_allow_block_filter;
  import ipf_pkg::*;

  localparam int ALLOW_TBL = 0;
  localparam int BLOCK_TBL = 1;
  localparam logic DIR_SRC = 1'b0;
  localparam logic DIR_DST = 1'b1;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = 8'hFF;
  localparam logic [31:0] ADDR_A = 32'hC0A8_0001;
  localparam logic [31:0] ADDR_B = 32'h0A00_0002;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipf_in_if  hdr_if ();
  ipf_out_if verdict_if ();
  ipf_cfg_if cfg_if ();

  ip_port_allow_block_filter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (hdr_if),
    .out_o (verdict_if),
    .cfg_i (cfg_if)
  );

  bit               slot_used [2][SCAN_ENTRIES];
  logic [KEY_W-1:0] slot_key  [2][SCAN_ENTRIES];
  logic             glob_allow = 1'b0;
  logic             glob_block = 1'b0;
  rslt_t            expected_verdicts[$];
  rslt_t            oldest_verdict;
  int               error_count = 0;
  int               sender_idle_pct = 0;
  int               stall_pct = 0;
  logic [31:0]      addr_pool [6];
  logic [15:0]      port_pool [4];
  logic [7:0]       proto_pool[4];

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    verdict_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no transaction pending", 8'd0, 8'd0);
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        if (verdict_if.verdict !== oldest_verdict.verdict)
          report_mismatch("verdict", 8'(verdict_if.verdict), 8'(oldest_verdict.verdict));
        if (verdict_if.match_reason !== oldest_verdict.match_reason)
          report_mismatch("match_reason", 8'(verdict_if.match_reason),
                          8'(oldest_verdict.match_reason));
        if (verdict_if.op_status !== oldest_verdict.op_status)
          report_mismatch("op_status", 8'(verdict_if.op_status),
                          8'(oldest_verdict.op_status));
      end
    end
  end

  function automatic logic [KEY_W-1:0] pack_key(input logic [31:0] ip,
                                                input logic [7:0] proto,
                                                input logic dir,
                                                input logic [15:0] port);
    return {ip, proto, dir, port};
  endfunction

  function automatic int table_depth(input int t);
    return (t == ALLOW_TBL) ? ALLOW_ENTRIES : BLOCK_ENTRIES;
  endfunction

  function automatic bit rule_hit(input int t, input logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < table_depth(t); i++)
      if (slot_used[t][i] && slot_key[t][i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int free_slots(input int t);
    int i;
    int n;
    n = 0;
    for (i = 0; i < table_depth(t); i++)
      if (!slot_used[t][i]) n++;
    return n;
  endfunction

  function automatic status_e rule_insert(input int t, input logic [KEY_W-1:0] k);
    int i;
    int spare;
    spare = -1;
    for (i = 0; i < table_depth(t); i++) begin
      if (slot_used[t][i] && slot_key[t][i] == k) return STAT_OK;
      if (!slot_used[t][i] && spare < 0) spare = i;
    end
    if (spare < 0) return STAT_FULL;
    slot_used[t][spare] = 1'b1;
    slot_key[t][spare] = k;
    return STAT_OK;
  endfunction

  function automatic status_e rule_delete(input int t, input logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < table_depth(t); i++) begin
      if (slot_used[t][i] && slot_key[t][i] == k) begin
        slot_used[t][i] = 1'b0;
        return STAT_OK;
      end
    end
    return STAT_MISSING;
  endfunction

  // Updates the rule tables and returns the verdict the filter must give.
  function automatic rslt_t predict_filter(input req_t r);
    rslt_t            res;
    reason_e          rsn;
    logic [KEY_W-1:0] k, ks, kd, ksp, kdp;
    logic [15:0]      sp, dp;
    logic             egress, good;
    res.verdict = 1'b0;
    res.match_reason = RSN_NONE;
    res.op_status = STAT_OK;
    k = pack_key(r.rule_ip, r.rule_proto, r.rule_direction, r.rule_port);
    case (r.mode)
      MODE_INS_ALLOW: res.op_status = rule_insert(ALLOW_TBL, k);
      MODE_INS_BLOCK: res.op_status = rule_insert(BLOCK_TBL, k);
      MODE_DEL_ALLOW: res.op_status = rule_delete(ALLOW_TBL, k);
      MODE_DEL_BLOCK: res.op_status = rule_delete(BLOCK_TBL, k);
      MODE_INGRESS, MODE_EGRESS: begin
        egress = (r.mode == MODE_EGRESS);
        good = (r.frame_len >= MIN_IP_LEN) && (r.ether_type == ETH_IPV4);
        if (egress && glob_allow) begin
          rsn = RSN_GLOBAL_ALLOW;
        end else if (!good) begin
          rsn = RSN_NOT_IPV4;
        end else if (glob_allow) begin
          rsn = RSN_GLOBAL_ALLOW;
        end else begin
          sp = '0;
          dp = '0;
          if ((r.ip_proto == PROTO_TCP || r.ip_proto == PROTO_UDP) &&
              r.frame_len >= MIN_PORT_LEN) begin
            sp = r.l4_sport;
            dp = r.l4_dport;
          end
          ks  = pack_key(r.src_ip, r.ip_proto, DIR_SRC, 16'd0);
          kd  = pack_key(r.dst_ip, r.ip_proto, DIR_DST, 16'd0);
          ksp = pack_key(r.src_ip, r.ip_proto, DIR_SRC, sp);
          kdp = pack_key(r.dst_ip, r.ip_proto, DIR_DST, dp);
          if (!egress && rule_hit(ALLOW_TBL, ksp))      rsn = RSN_ALLOW_SRC_PORT;
          else if (rule_hit(ALLOW_TBL, kdp))            rsn = RSN_ALLOW_DST_PORT;
          else if (!egress && rule_hit(ALLOW_TBL, ks))  rsn = RSN_ALLOW_SRC;
          else if (rule_hit(ALLOW_TBL, kd))             rsn = RSN_ALLOW_DST;
          else if (glob_block)                          rsn = RSN_GLOBAL_BLOCK;
          else if (!egress && rule_hit(BLOCK_TBL, ksp)) rsn = RSN_BLOCK_SRC_PORT;
          else if (rule_hit(BLOCK_TBL, kdp))            rsn = RSN_BLOCK_DST_PORT;
          else if (!egress && rule_hit(BLOCK_TBL, ks))  rsn = RSN_BLOCK_SRC;
          else if (rule_hit(BLOCK_TBL, kd))             rsn = RSN_BLOCK_DST;
          else                                          rsn = RSN_NONE;
          res.verdict = (rsn >= RSN_GLOBAL_BLOCK) && (rsn <= RSN_BLOCK_DST);
        end
        res.match_reason = rsn;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.mode           = 3'($urandom_range(7));
    r.frame_len      = 16'($urandom);
    r.ether_type     = 16'($urandom);
    r.ip_proto       = 8'($urandom);
    r.src_ip         = $urandom;
    r.dst_ip         = $urandom;
    r.l4_sport       = 16'($urandom);
    r.l4_dport       = 16'($urandom);
    r.rule_ip        = $urandom;
    r.rule_proto     = 8'($urandom);
    r.rule_direction = 1'($urandom);
    r.rule_port      = 16'($urandom);
    return r;
  endfunction

  // Mostly well-formed headers and rule edits drawn from small pools, so
  // that lookups hit the tables often; a few items are pure noise.
  function automatic req_t random_item();
    req_t r;
    int   pick;
    r = noise_req();
    pick = $urandom_range(99);
    if (pick < 5) return r;
    r.ip_proto       = proto_pool[$urandom_range(3)];
    r.src_ip         = addr_pool[$urandom_range(5)];
    r.dst_ip         = addr_pool[$urandom_range(5)];
    r.l4_sport       = port_pool[$urandom_range(3)];
    r.l4_dport       = port_pool[$urandom_range(3)];
    r.rule_ip        = addr_pool[$urandom_range(5)];
    r.rule_proto     = proto_pool[$urandom_range(3)];
    r.rule_port      = port_pool[$urandom_range(3)];
    if ($urandom_range(9) != 0) r.ether_type = ETH_IPV4;
    case ($urandom_range(19))
      0:       r.frame_len = 16'($urandom_range(33));
      1, 2, 3: r.frame_len = 16'($urandom_range(53, 34));
      default: r.frame_len = 16'($urandom_range(1518, 54));
    endcase
    if (pick < 30)      r.mode = MODE_INGRESS;
    else if (pick < 50) r.mode = MODE_EGRESS;
    else if (pick < 62) r.mode = MODE_INS_ALLOW;
    else if (pick < 74) r.mode = MODE_INS_BLOCK;
    else if (pick < 87) r.mode = MODE_DEL_ALLOW;
    else                r.mode = MODE_DEL_BLOCK;
    return r;
  endfunction

  task automatic send_item(input req_t r);
    hdr_if.valid          <= 1'b1;
    hdr_if.mode           <= r.mode;
    hdr_if.frame_len      <= r.frame_len;
    hdr_if.ether_type     <= r.ether_type;
    hdr_if.ip_proto       <= r.ip_proto;
    hdr_if.src_ip         <= r.src_ip;
    hdr_if.dst_ip         <= r.dst_ip;
    hdr_if.l4_sport       <= r.l4_sport;
    hdr_if.l4_dport       <= r.l4_dport;
    hdr_if.rule_ip        <= r.rule_ip;
    hdr_if.rule_proto     <= r.rule_proto;
    hdr_if.rule_direction <= r.rule_direction;
    hdr_if.rule_port      <= r.rule_port;
    @(posedge clk_i);
    while (!hdr_if.ready) @(posedge clk_i);
    expected_verdicts.push_back(predict_filter(r));
    if ($urandom_range(99) < sender_idle_pct) begin
      hdr_if.valid <= 1'b0;
      repeat ($urandom_range(90, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_header(input logic [2:0] mode, input logic [15:0] len,
                             input logic [15:0] etype, input logic [7:0] proto,
                             input logic [31:0] sip, input logic [31:0] dip,
                             input logic [15:0] sport, input logic [15:0] dport);
    req_t r;
    r = noise_req();
    r.mode       = mode;
    r.frame_len  = len;
    r.ether_type = etype;
    r.ip_proto   = proto;
    r.src_ip     = sip;
    r.dst_ip     = dip;
    r.l4_sport   = sport;
    r.l4_dport   = dport;
    send_item(r);
  endtask

  task automatic send_rule(input logic [2:0] mode, input logic [31:0] ip,
                           input logic [7:0] proto, input logic dir,
                           input logic [15:0] port);
    req_t r;
    r = noise_req();
    r.mode           = mode;
    r.rule_ip        = ip;
    r.rule_proto     = proto;
    r.rule_direction = dir;
    r.rule_port      = port;
    send_item(r);
  endtask

  task automatic wait_all_results();
    hdr_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val,
                           input bit hold);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == CFG_GLOBAL_ALLOW)      glob_allow = val;
    else if (idx == CFG_GLOBAL_BLOCK) glob_block = val;
    if (!hold) cfg_if.valid <= 1'b0;
  endtask

  task automatic set_globals(input logic allow_all, input logic block_all);
    wait_all_results();
    write_reg(CFG_GLOBAL_ALLOW, allow_all, 1'b1);
    write_reg(CFG_GLOBAL_BLOCK, block_all, 1'b0);
  endtask

  task automatic test_config_writes();
    write_reg(CFG_GLOBAL_ALLOW, 1'b1, 1'b1);
    write_reg(CFG_GLOBAL_BLOCK, 1'b1, 1'b1);
    write_reg(CFG_GLOBAL_ALLOW, 1'b0, 1'b1);
    write_reg(CFG_GLOBAL_BLOCK, 1'b0, 1'b1);
    write_reg(CFG_IDX_SPARE, 1'b1, 1'b1);
    write_reg(CFG_IDX_TOP, 1'b1, 1'b0);
    send_header(MODE_INGRESS, 16'd60, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd2);
    send_header(MODE_EGRESS, 16'd60, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd2);
  endtask

  task automatic test_short_frames();
    send_header(MODE_INGRESS, 16'd0, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd9, 16'd80);
    send_header(MODE_EGRESS, 16'd13, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd9, 16'd80);
    send_header(MODE_INGRESS, 16'd14, ETH_IPV4, PROTO_UDP, ADDR_A, ADDR_B, 16'd9, 16'd80);
    send_header(MODE_INGRESS, 16'd33, ETH_IPV4, PROTO_UDP, ADDR_A, ADDR_B, 16'd9, 16'd80);
    send_header(MODE_INGRESS, 16'hFFFF, ETH_IPV6, PROTO_TCP, ADDR_A, ADDR_B, 16'd9, 16'd80);
    send_header(MODE_EGRESS, 16'd34, 16'h0000, PROTO_TCP, ADDR_A, ADDR_B, 16'd9, 16'd80);
  endtask

  task automatic test_rule_order();
    send_rule(MODE_INS_ALLOW, ADDR_A, PROTO_TCP, DIR_SRC, 16'd1000);
    send_rule(MODE_INS_ALLOW, ADDR_A, PROTO_TCP, DIR_SRC, 16'd1000);
    send_header(MODE_INGRESS, 16'd54, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1000, 16'd80);
    send_header(MODE_EGRESS, 16'd54, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1000, 16'd80);
    send_header(MODE_INGRESS, 16'd53, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1000, 16'd80);
    send_rule(MODE_INS_BLOCK, ADDR_B, PROTO_UDP, DIR_DST, 16'd0);
    send_header(MODE_INGRESS, 16'd40, ETH_IPV4, PROTO_UDP, ADDR_A, ADDR_B, 16'd5, 16'd7);
    send_header(MODE_EGRESS, 16'd40, ETH_IPV4, PROTO_UDP, ADDR_A, ADDR_B, 16'd5, 16'd7);
    send_rule(MODE_INS_ALLOW, ADDR_A, PROTO_UDP, DIR_SRC, 16'd0);
    send_header(MODE_INGRESS, 16'd100, ETH_IPV4, PROTO_UDP, ADDR_A, ADDR_B, 16'd5, 16'd7);
    send_header(MODE_EGRESS, 16'd100, ETH_IPV4, PROTO_UDP, ADDR_A, ADDR_B, 16'd5, 16'd7);
    send_header(MODE_INGRESS, 16'd100, ETH_IPV4, PROTO_ICMP, ADDR_A, ADDR_B, 16'd5, 16'd7);
    send_rule(MODE_DEL_ALLOW, ADDR_B, PROTO_TCP, DIR_DST, 16'd9);
    send_rule(MODE_DEL_ALLOW, ADDR_A, PROTO_TCP, DIR_SRC, 16'd1000);
    send_rule(MODE_DEL_ALLOW, ADDR_A, PROTO_UDP, DIR_SRC, 16'd0);
    send_rule(MODE_DEL_BLOCK, ADDR_B, PROTO_UDP, DIR_DST, 16'd0);
    send_rule(MODE_DEL_BLOCK, ADDR_B, PROTO_UDP, DIR_DST, 16'd0);
    send_rule(MODE_SPARE_LO, ADDR_A, PROTO_TCP, DIR_SRC, 16'd0);
    send_rule(MODE_SPARE_HI, ADDR_A, PROTO_TCP, DIR_SRC, 16'd0);
    send_rule(MODE_INS_BLOCK, 32'hFFFF_FFFF, 8'hFF, DIR_DST, 16'hFFFF);
    send_rule(MODE_DEL_BLOCK, 32'hFFFF_FFFF, 8'hFF, DIR_DST, 16'hFFFF);
  endtask

  task automatic test_global_flags();
    set_globals(1'b1, 1'b0);
    send_header(MODE_EGRESS, 16'd10, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    send_header(MODE_INGRESS, 16'd10, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    send_header(MODE_INGRESS, 16'd60, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    set_globals(1'b0, 1'b1);
    send_header(MODE_INGRESS, 16'd60, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    send_rule(MODE_INS_ALLOW, ADDR_B, PROTO_TCP, DIR_DST, 16'd0);
    send_header(MODE_INGRESS, 16'd40, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    send_header(MODE_INGRESS, 16'd60, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    send_header(MODE_EGRESS, 16'd60, ETH_IPV4, PROTO_TCP, ADDR_A, ADDR_B, 16'd1, 16'd80);
    send_rule(MODE_DEL_ALLOW, ADDR_B, PROTO_TCP, DIR_DST, 16'd0);
    set_globals(1'b0, 1'b0);
  endtask

  // Fills each table with random keys, pushes past its capacity, then
  // empties it again, with duplicate and missing keys along the way.
  task automatic test_table_full();
    req_t        filled[$];
    req_t        r;
    int          t;
    logic [2:0]  ins_mode, del_mode;
    for (t = ALLOW_TBL; t <= BLOCK_TBL; t++) begin
      ins_mode = (t == ALLOW_TBL) ? MODE_INS_ALLOW : MODE_INS_BLOCK;
      del_mode = (t == ALLOW_TBL) ? MODE_DEL_ALLOW : MODE_DEL_BLOCK;
      filled.delete();
      while (free_slots(t) > 0) begin
        r = noise_req();
        r.mode = ins_mode;
        send_item(r);
        filled.push_back(r);
      end
      repeat (2) begin
        r = noise_req();
        r.mode = ins_mode;
        send_item(r);
      end
      send_item(filled[0]);
      foreach (filled[i]) begin
        r = filled[i];
        r.mode = del_mode;
        send_item(r);
      end
      r = filled[0];
      r.mode = del_mode;
      send_item(r);
    end
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_p,
                           input logic allow_all, input logic block_all);
    set_globals(allow_all, block_all);
    sender_idle_pct = idle_pct;
    stall_pct = stall_p;
    repeat (n) send_item(random_item());
    wait_all_results();
  endtask

  initial begin
    rst_ni                <= 1'b0;
    hdr_if.valid          <= 1'b0;
    hdr_if.mode           <= MODE_INGRESS;
    hdr_if.frame_len      <= '0;
    hdr_if.ether_type     <= '0;
    hdr_if.ip_proto       <= '0;
    hdr_if.src_ip         <= '0;
    hdr_if.dst_ip         <= '0;
    hdr_if.l4_sport       <= '0;
    hdr_if.l4_dport       <= '0;
    hdr_if.rule_ip        <= '0;
    hdr_if.rule_proto     <= '0;
    hdr_if.rule_direction <= DIR_SRC;
    hdr_if.rule_port      <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.idx            <= CFG_GLOBAL_ALLOW;
    cfg_if.data           <= 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    port_pool[0] = 16'd0;
    for (int i = 1; i < 4; i++) port_pool[i] = 16'($urandom);
    proto_pool[0] = PROTO_TCP;
    proto_pool[1] = PROTO_UDP;
    proto_pool[2] = PROTO_ICMP;
    proto_pool[3] = 8'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_config_writes();
    test_short_frames();
    test_rule_order();
    test_global_flags();
    test_table_full();
    run_phase(200, 0, 0, 1'b0, 1'b0);
    run_phase(150, 71, 0, 1'b0, 1'b1);
    run_phase(100, 0, 71, 1'b1, 1'b0);
    run_phase(150, 32, 32, 1'b0, 1'b0);
    run_phase(100, 0, 0, 1'b1, 1'b1);

    wait_all_results();
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
